[rtl/echo_light_tone_mapper_core_defines.svh]
// assertion macros for the echo light tone mapper
// used by the top level; expects clk and rst_n in the including scope
`ifndef ECHO_LIGHT_TONE_MAPPER_CORE_DEFINES_SVH
`define ECHO_LIGHT_TONE_MAPPER_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define ELTM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eltm check failed");
// next-cycle implication
`define ELTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eltm check failed");
`else
`define ELTM_ASSERT_SAME(label, ante, cons)
`define ELTM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/eltm_pkg.sv]
// types, constants and lookup functions of the echo light tone mapper
// no dependencies
package eltm_pkg;

  localparam int CAPTURE_TIME_W = 16;
  localparam int LIGHT_W        = 10;
  localparam int PITCH_W        = 8;
  localparam int VOLUME_W       = 3;
  localparam int STAMP_MAX_W    = 32;

  typedef enum logic {
    MODE_CAPTURE = 1'b0,
    MODE_POLL    = 1'b1
  } item_mode_t;

  // continuous pitch: floor(w*59/54500) as (w*SPAN_MUL) >> SPAN_SHIFT,
  // exact for every w below the saturation point
  localparam int SPAN_IN_W  = 18;
  localparam int SPAN_MUL_W = 25;
  localparam int SPAN_PROD_W = SPAN_IN_W + SPAN_MUL_W;
  localparam int SPAN_SHIFT = 34;
  localparam logic [SPAN_MUL_W-1:0] SPAN_MUL = 25'd18598391;
  // smallest width whose pitch exceeds the 8-bit range
  localparam logic [STAMP_MAX_W-1:0] SAT_WIDTH = 32'd181051;
  localparam logic [PITCH_W-1:0] PITCH_BASE = 8'd60;
  localparam logic [PITCH_W-1:0] PITCH_SAT  = 8'd255;

  localparam logic [STAMP_MAX_W-1:0] STEP_LIMIT [7] = '{
    32'd12313, 32'd19125, 32'd25938, 32'd32750, 32'd39563, 32'd46375, 32'd53188
  };
  localparam logic [PITCH_W-1:0] STEP_PITCH [8] = '{
    8'd119, 8'd106, 8'd95, 8'd89, 8'd80, 8'd71, 8'd63, 8'd60
  };
  localparam logic [LIGHT_W-1:0] LIGHT_LIMIT [7] = '{
    10'd576, 10'd623, 10'd669, 10'd715, 10'd761, 10'd808, 10'd854
  };

  function automatic logic [PITCH_W-1:0] pitch_step(input logic [STAMP_MAX_W-1:0] w);
    logic [PITCH_W-1:0] p;
    p = STEP_PITCH[7];
    for (int i = 6; i >= 0; i--) begin
      if (w < STEP_LIMIT[i]) p = STEP_PITCH[i];
    end
    return p;
  endfunction

  function automatic logic [VOLUME_W-1:0] volume_of(input logic [LIGHT_W-1:0] light);
    logic [VOLUME_W-1:0] v;
    v = '0;
    for (int i = 6; i >= 0; i--) begin
      if (light < LIGHT_LIMIT[i]) v = VOLUME_W'(7 - i);
    end
    return v;
  endfunction

endpackage

[rtl/eltm_channels.sv]
// valid/ready channel interfaces of the echo light tone mapper
// depends on eltm_pkg
interface eltm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [eltm_pkg::CAPTURE_TIME_W-1:0] capture_time;
  logic                                button_level;
  logic [eltm_pkg::LIGHT_W-1:0]        light_level;

  modport source (output valid, mode, capture_time, button_level, light_level,
                  input ready);
  modport sink   (input valid, mode, capture_time, button_level, light_level,
                  output ready);
endinterface

interface eltm_out_if;
  logic                                valid;
  logic                                ready;
  logic [eltm_pkg::PITCH_W-1:0]        pitch_compare;
  logic [eltm_pkg::VOLUME_W-1:0]       volume_level;
  logic                                continuous_flag;
  logic [eltm_pkg::CAPTURE_TIME_W-1:0] echo_width;

  modport source (output valid, pitch_compare, volume_level, continuous_flag, echo_width,
                  input ready);
  modport sink   (input valid, pitch_compare, volume_level, continuous_flag, echo_width,
                  output ready);
endinterface

[rtl/echo_light_tone_mapper_core.sv]
// echo light tone mapper top level: edge pairing, mode button, pitch and volume
// depends on eltm_pkg, eltm_channels and echo_light_tone_mapper_core_defines.svh
`include "echo_light_tone_mapper_core_defines.svh"

// Takes one item per clock on in_ch. A capture item (mode 0) stores an echo
// edge stamp, alternately as start and end; each end edge updates the held
// pulse width, wrapping as all-ones minus start plus end when end is not above
// start. Capture items give no result. A poll item (mode 1) handles the mode
// button (each press edge toggles continuous/discrete pitch) and returns one
// transfer on out_ch with the pitch compare value, a 3-bit volume from the
// light sample, the mode flag and the held width. Throughput is one item per
// cycle while no poll waits on a held result; a poll result passes the input
// register, then the result register. The longest path is the constant
// 18 x 25 multiply behind the continuous pitch into the result register.
// A waiting result does not block capture items, and a new poll is taken
// in the same cycle the held result leaves.
module echo_light_tone_mapper_core #(
  parameter int STAMP_WIDTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  eltm_in_if.sink    in_ch,
  eltm_out_if.source out_ch
);

  localparam int CAP_W = eltm_pkg::CAPTURE_TIME_W;
  localparam int CMP_W = eltm_pkg::STAMP_MAX_W;
  localparam int EXT_W = (STAMP_WIDTH > CAP_W) ? STAMP_WIDTH : CAP_W;

  // input register stage
  logic                         s1_valid_r;
  eltm_pkg::item_mode_t         s1_mode_r;
  logic [STAMP_WIDTH-1:0]       s1_stamp_r;
  logic                         s1_button_r;
  logic [eltm_pkg::LIGHT_W-1:0] s1_light_r;

  // edge pairing and button state
  logic                   expect_start_r, expect_start_nxt;
  logic [STAMP_WIDTH-1:0] start_stamp_r, start_stamp_nxt;
  logic [STAMP_WIDTH-1:0] width_hold_r, width_hold_nxt;
  logic                   continuous_r, continuous_nxt;
  logic                   button_held_r, button_held_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [eltm_pkg::PITCH_W-1:0]  pitch_r;
  logic [eltm_pkg::VOLUME_W-1:0] volume_r;
  logic                          cont_flag_r;
  logic [CAP_W-1:0]              width_out_r;

  logic                          s1_adv;
  logic                          s1_is_poll;
  logic [EXT_W-1:0]              cap_ext;
  logic [CMP_W-1:0]              width_cmp;
  logic                          pitch_sat;
  logic [eltm_pkg::SPAN_PROD_W-1:0] span_prod;
  logic [eltm_pkg::PITCH_W-1:0]  pitch_cont;
  logic [eltm_pkg::PITCH_W-1:0]  pitch_disc;
  logic [eltm_pkg::PITCH_W-1:0]  pitch_sel;

  // handshake: capture items never wait on the result side
  assign s1_is_poll = (s1_mode_r == eltm_pkg::MODE_POLL);
  assign s1_adv     = s1_valid_r && (!s1_is_poll || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // stamp zero-extended here, cut to STAMP_WIDTH bits when registered
  assign cap_ext = EXT_W'(in_ch.capture_time);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_mode_r   <= eltm_pkg::item_mode_t'(in_ch.mode);
      s1_stamp_r  <= STAMP_WIDTH'(cap_ext);
      s1_button_r <= in_ch.button_level;
      s1_light_r  <= in_ch.light_level;
    end
  end

  // state update for the item leaving the input stage
  always_comb begin
    expect_start_nxt = expect_start_r;
    start_stamp_nxt  = start_stamp_r;
    width_hold_nxt   = width_hold_r;
    continuous_nxt   = continuous_r;
    button_held_nxt  = button_held_r;
    if (s1_adv) begin
      if (!s1_is_poll) begin
        if (expect_start_r) begin
          start_stamp_nxt  = s1_stamp_r;
          expect_start_nxt = 1'b0;
        end else begin
          expect_start_nxt = 1'b1;
          if (s1_stamp_r > start_stamp_r) begin
            width_hold_nxt = s1_stamp_r - start_stamp_r;
          end else begin
            // all-ones minus start plus end, one short of a full wrap
            width_hold_nxt = ~start_stamp_r + s1_stamp_r;
          end
        end
      end else begin
        if (!button_held_r) begin
          if (s1_button_r) begin
            continuous_nxt  = !continuous_r;
            button_held_nxt = 1'b1;
          end
        end else if (!s1_button_r) begin
          button_held_nxt = 1'b0;
        end
      end
    end
  end

  // continuous pitch by reciprocal multiply, saturated at the top
  assign width_cmp  = CMP_W'(width_hold_r);
  assign pitch_sat  = (width_cmp >= eltm_pkg::SAT_WIDTH);
  assign span_prod  = eltm_pkg::SPAN_PROD_W'(width_cmp[eltm_pkg::SPAN_IN_W-1:0])
                    * eltm_pkg::SPAN_PROD_W'(eltm_pkg::SPAN_MUL);
  assign pitch_cont = pitch_sat ? eltm_pkg::PITCH_SAT
                    : span_prod[eltm_pkg::SPAN_SHIFT +: eltm_pkg::PITCH_W]
                      + eltm_pkg::PITCH_BASE;
  assign pitch_disc = eltm_pkg::pitch_step(width_cmp);
  assign pitch_sel  = continuous_nxt ? pitch_cont : pitch_disc;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_is_poll) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_start_r <= 1'b1;
      start_stamp_r  <= '0;
      width_hold_r   <= '0;
      continuous_r   <= 1'b1;
      button_held_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      expect_start_r <= expect_start_nxt;
      start_stamp_r  <= start_stamp_nxt;
      width_hold_r   <= width_hold_nxt;
      continuous_r   <= continuous_nxt;
      button_held_r  <= button_held_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // result payload, loaded by each poll transfer
  always_ff @(posedge clk) begin
    if (s1_adv && s1_is_poll) begin
      pitch_r     <= pitch_sel;
      volume_r    <= eltm_pkg::volume_of(s1_light_r);
      cont_flag_r <= continuous_nxt;
      width_out_r <= CAP_W'(width_hold_r);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.pitch_compare   = pitch_r;
  assign out_ch.volume_level    = volume_r;
  assign out_ch.continuous_flag = cont_flag_r;
  assign out_ch.echo_width      = width_out_r;

  // a poll leaving the input stage always shows up as a result
  `ELTM_ASSERT_NEXT(a_poll_gives_result, s1_adv && s1_is_poll, out_valid_r)
  // edges alternate between start and end on every capture
  `ELTM_ASSERT_NEXT(a_edge_alternates, s1_adv && !s1_is_poll, expect_start_r != $past(expect_start_r))
  // every pitch in use lies at or above the base value
  `ELTM_ASSERT_SAME(a_pitch_floor, out_valid_r, pitch_r >= eltm_pkg::PITCH_BASE)

endmodule

[bench/echo_light_tone_mapper_core_test.sv]
`timescale 1ns / 1ps
// self-checking bench for echo_light_tone_mapper_core: a directed table, then random items
// depends on eltm_pkg, eltm_channels and the core rtl; every result is checked in order
module echo_light_tone_mapper_core_test;
  import eltm_pkg::*;

  localparam int STAMP_W      = 16;
  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  localparam logic [STAMP_W-1:0] STAMP_ALL_ONES = '1;

  // discrete pitch steps and light thresholds, both ascending
  localparam logic [31:0] WIDTH_STEPS [7] = '{
    32'd12313, 32'd19125, 32'd25938, 32'd32750, 32'd39563, 32'd46375, 32'd53188
  };
  localparam logic [PITCH_W-1:0] PITCH_STEPS [8] = '{
    8'd119, 8'd106, 8'd95, 8'd89, 8'd80, 8'd71, 8'd63, 8'd60
  };
  localparam logic [LIGHT_W-1:0] LIGHT_STEPS [7] = '{
    10'd576, 10'd623, 10'd669, 10'd715, 10'd761, 10'd808, 10'd854
  };

  typedef struct packed {
    item_mode_t                 mode;
    logic [CAPTURE_TIME_W-1:0]  stamp;
    logic                       button;
    logic [LIGHT_W-1:0]         light;
  } tone_item_t;

  typedef struct packed {
    logic [PITCH_W-1:0]         pitch;
    logic [VOLUME_W-1:0]        volume;
    logic                       continuous;
    logic [CAPTURE_TIME_W-1:0]  width;
  } tone_result_t;

  typedef struct packed {
    tone_item_t   item;
    logic         pinned;
    tone_result_t result;
  } stim_row_t;

  logic clk;
  logic rst_n;

  eltm_in_if  in_ch ();
  eltm_out_if out_ch ();

  echo_light_tone_mapper_core #(
    .STAMP_WIDTH(STAMP_W)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // typed-in expectation that travels with the item on the input channel
  logic         row_pinned;
  tone_result_t row_result;

  // own copy of the block state
  logic                edge_is_start;
  logic [STAMP_W-1:0]  start_q;
  logic [STAMP_W-1:0]  end_q;
  logic [STAMP_W-1:0]  width_q;
  logic                continuous_q;
  logic                button_down_q;

  tone_result_t tone_due [$];
  stim_row_t    directed_rows [$];
  int           errors;
  int           cycles;
  bit           quiet;
  logic         button_now;
  logic [CAPTURE_TIME_W-1:0] last_stamp;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // updates the state for one item; returns 1 when the item gives a result
  function automatic bit tone_predict(input tone_item_t it, output tone_result_t res);
    logic [STAMP_W-1:0] stamp;
    logic [63:0]        scaled;
    int                 steps;
    stamp = it.stamp[STAMP_W-1:0];
    res = '0;
    if (it.mode == MODE_CAPTURE) begin
      if (edge_is_start) begin
        start_q = stamp;
        edge_is_start = 1'b0;
      end else begin
        end_q = stamp;
        edge_is_start = 1'b1;
        // wrap keeps the one-short-of-full-span behavior
        if (end_q > start_q) width_q = end_q - start_q;
        else width_q = STAMP_ALL_ONES - start_q + end_q;
      end
      return 1'b0;
    end
    if (!button_down_q) begin
      if (it.button) begin
        continuous_q = ~continuous_q;
        button_down_q = 1'b1;
      end
    end else if (!it.button) begin
      button_down_q = 1'b0;
    end
    if (continuous_q) begin
      scaled = 64'(width_q) * 64'd59 / 64'd54500 + 64'd60;
      res.pitch = (scaled > 64'd255) ? 8'hFF : scaled[PITCH_W-1:0];
    end else begin
      steps = 0;
      for (int i = 0; i < 7; i++) if (32'(width_q) >= WIDTH_STEPS[i]) steps++;
      res.pitch = PITCH_STEPS[steps];
    end
    steps = 0;
    for (int i = 0; i < 7; i++) if (it.light >= LIGHT_STEPS[i]) steps++;
    res.volume = VOLUME_W'(7 - steps);
    res.continuous = continuous_q;
    res.width = CAPTURE_TIME_W'(width_q);
    return 1'b1;
  endfunction

  function automatic tone_item_t cap_item(input logic [CAPTURE_TIME_W-1:0] stamp);
    tone_item_t it;
    it.mode = MODE_CAPTURE;
    it.stamp = stamp;
    // ignored by the block on a capture
    it.button = 1'($urandom_range(0, 1));
    it.light = LIGHT_W'($urandom_range(0, 1023));
    return it;
  endfunction

  function automatic tone_item_t poll_item(input logic button, input logic [LIGHT_W-1:0] light);
    tone_item_t it;
    it.mode = MODE_POLL;
    it.stamp = CAPTURE_TIME_W'($urandom_range(0, 65535));
    it.button = button;
    it.light = light;
    return it;
  endfunction

  function automatic stim_row_t free_row(input tone_item_t it);
    stim_row_t row;
    row = '0;
    row.item = it;
    return row;
  endfunction

  // rows right after reset: width 0, continuous, so pitch is the base value
  function automatic stim_row_t fixed_row(input logic [LIGHT_W-1:0] light,
                                          input logic [VOLUME_W-1:0] volume);
    stim_row_t row;
    row.item = poll_item(1'b0, light);
    row.pinned = 1'b1;
    row.result.pitch = 8'd60;
    row.result.volume = volume;
    row.result.continuous = 1'b1;
    row.result.width = '0;
    return row;
  endfunction

  function automatic logic [CAPTURE_TIME_W-1:0] rand_stamp(input logic [CAPTURE_TIME_W-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return prev;
      1:       return '0;
      2:       return '1;
      3:       return prev + CAPTURE_TIME_W'($urandom_range(1, 600));
      4:       return prev - CAPTURE_TIME_W'($urandom_range(1, 600));
      default: return CAPTURE_TIME_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [LIGHT_W-1:0] rand_light();
    if ($urandom_range(0, 2) == 0)
      return LIGHT_STEPS[$urandom_range(0, 6)] - 10'd1 + LIGHT_W'($urandom_range(0, 2));
    return LIGHT_W'($urandom_range(0, 1023));
  endfunction

  task automatic log_mismatch(input string what, input tone_result_t want,
                              input tone_result_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display({"mismatch (%s): expected pitch %0d vol %0d cont %0b width %0d,",
                " got pitch %0d vol %0d cont %0b width %0d"},
               what, want.pitch, want.volume, want.continuous, want.width,
               got.pitch, got.volume, got.continuous, got.width);
  endtask

  // one item on the input channel, with an optional idle burst before it
  task automatic send_row(input stim_row_t row);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= row.item.mode;
    in_ch.capture_time <= row.item.stamp;
    in_ch.button_level <= row.item.button;
    in_ch.light_level  <= row.item.light;
    row_pinned         <= row.pinned;
    row_result         <= row.result;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_capture();
    last_stamp = rand_stamp(last_stamp);
    send_row(free_row(cap_item(last_stamp)));
  endtask

  task automatic send_poll();
    // button mostly holds its level over several polls
    if ($urandom_range(0, 3) == 0) button_now = ~button_now;
    send_row(free_row(poll_item(button_now, rand_light())));
  endtask

  // scoreboard: results are checked against the oldest expectation, then
  // each accepted input transfer is run through the predictor
  always @(posedge clk) begin : scoreboard
    tone_item_t   taken;
    tone_result_t got;
    tone_result_t predicted;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.pitch = out_ch.pitch_compare;
        got.volume = out_ch.volume_level;
        got.continuous = out_ch.continuous_flag;
        got.width = out_ch.echo_width;
        if (tone_due.size() == 0) log_mismatch("no result expected", '0, got);
        else begin
          predicted = tone_due.pop_front();
          if (got !== predicted) log_mismatch("field", predicted, got);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        taken.mode = item_mode_t'(in_ch.mode);
        taken.stamp = in_ch.capture_time;
        taken.button = in_ch.button_level;
        taken.light = in_ch.light_level;
        if (tone_predict(taken, predicted))
          tone_due.push_back(row_pinned ? row_result : predicted);
      end
    end
  end

  // result side: ready stalls in random bursts until the quiet stretch
  initial begin
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int sent;
    int polls;
    int kind;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_CAPTURE;
    in_ch.capture_time = '0;
    in_ch.button_level = 1'b0;
    in_ch.light_level = '0;
    row_pinned = 1'b0;
    row_result = '0;
    rst_n = 1'b0;
    quiet = 1'b0;
    errors = 0;
    cycles = 0;
    button_now = 1'b0;
    last_stamp = '0;
    edge_is_start = 1'b1;
    start_q = '0;
    end_q = '0;
    width_q = '0;
    continuous_q = 1'b1;
    button_down_q = 1'b0;

    // light extremes and the edges of the volume thresholds
    directed_rows.push_back(fixed_row(10'd0, 3'd7));
    directed_rows.push_back(fixed_row(10'd1023, 3'd0));
    directed_rows.push_back(fixed_row(10'd575, 3'd7));
    directed_rows.push_back(fixed_row(10'd576, 3'd6));
    directed_rows.push_back(fixed_row(10'd853, 3'd1));
    directed_rows.push_back(fixed_row(10'd854, 3'd0));
    // equal stamps give the all-ones width
    directed_rows.push_back(free_row(cap_item(16'd100)));
    directed_rows.push_back(free_row(cap_item(16'd100)));
    directed_rows.push_back(free_row(poll_item(1'b0, 10'd600)));
    // end wraps from the top stamp to zero
    directed_rows.push_back(free_row(cap_item(16'hFFFF)));
    directed_rows.push_back(free_row(cap_item(16'h0000)));
    directed_rows.push_back(free_row(poll_item(1'b0, 10'd700)));
    // widest plain pulse
    directed_rows.push_back(free_row(cap_item(16'h0000)));
    directed_rows.push_back(free_row(cap_item(16'hFFFF)));
    // press toggles to discrete, holding and releasing do nothing more
    directed_rows.push_back(free_row(poll_item(1'b1, 10'd300)));
    directed_rows.push_back(free_row(poll_item(1'b1, 10'd300)));
    directed_rows.push_back(free_row(poll_item(1'b0, 10'd900)));
    // discrete step boundary at the first threshold, from both sides
    directed_rows.push_back(free_row(cap_item(16'd1000)));
    directed_rows.push_back(free_row(cap_item(16'd13313)));
    directed_rows.push_back(free_row(poll_item(1'b0, 10'd650)));
    directed_rows.push_back(free_row(cap_item(16'd5)));
    directed_rows.push_back(free_row(cap_item(16'd12317)));
    directed_rows.push_back(free_row(poll_item(1'b0, 10'd650)));
    // second press returns to continuous
    directed_rows.push_back(free_row(poll_item(1'b1, 10'd800)));
    directed_rows.push_back(free_row(poll_item(1'b0, 10'd800)));
    // last discrete threshold
    directed_rows.push_back(free_row(cap_item(16'd0)));
    directed_rows.push_back(free_row(cap_item(16'd53188)));
    directed_rows.push_back(free_row(poll_item(1'b1, 10'd100)));
    directed_rows.push_back(free_row(poll_item(1'b0, 10'd100)));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_row(directed_rows[i]);

    // mostly start/end pairs followed by polls, with lone edges and
    // poll runs mixed in to break the pairing
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        send_capture();
        send_capture();
        polls = $urandom_range(1, 4);
        repeat (polls) send_poll();
        sent += 2 + polls;
      end else if (kind <= 8) begin
        send_capture();
        sent++;
      end else begin
        polls = $urandom_range(1, 6);
        repeat (polls) send_poll();
        sent += polls;
      end
    end
    in_ch.valid <= 1'b0;

    while (tone_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[echo_light_tone_mapper_core.f]
+incdir+rtl
rtl/eltm_pkg.sv
rtl/eltm_channels.sv
rtl/echo_light_tone_mapper_core.sv
bench/echo_light_tone_mapper_core_test.sv
